// ===== design/beeper_tone_pattern_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// Beeper tone pattern sequencer assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ---------------------------------------------------------------------------
`ifndef BEEPER_TONE_PATTERN_SEQUENCER_DEFINES_SVH
`define BEEPER_TONE_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bts same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts next-cycle check failed");

`endif

// ===== design/bts_pkg.sv =====
// ---------------------------------------------------------------------------
// Beeper tone pattern sequencer package
// Widths, pattern timing constants, codes and controller/datapath types.
// ---------------------------------------------------------------------------
package bts_pkg;

  localparam int FREQ_W     = 16;
  localparam int VOL_W      = 7;
  localparam int PAT_W      = 8;
  localparam int STAGE_W    = 4;
  localparam int CD_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 16;   // period and pulse counts
  localparam int DIVD_W     = 23;   // holds 65535 * 100
  localparam int DIVS_W     = 16;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int RECIP_W    = 24;
  localparam int PULSE_SHIFT = 30;
  localparam int SCALED_W   = DIVD_W + RECIP_W;

  localparam logic [CD_W-1:0] SINGLE_BEEP_TICKS = CD_W'(30);
  localparam logic [CD_W-1:0] DOUBLE_STEP_TICKS = CD_W'(50);
  localparam logic [CD_W-1:0] SWEEP_STEP_TICKS  = CD_W'(40);

  localparam logic [FREQ_W-1:0] SWEEP_BASE_HZ  = FREQ_W'(1000);
  localparam logic [FREQ_W-1:0] SWEEP_DELTA_HZ = FREQ_W'(25);
  localparam logic [FREQ_W-1:0] FREQ_MIN_HZ    = FREQ_W'(16);
  localparam logic [FREQ_W-1:0] FREQ_RESET_HZ  = FREQ_W'(1000);

  localparam logic [DIVD_W-1:0] US_PER_SECOND = DIVD_W'(1000000);
  localparam logic [VOL_W-1:0]  PERCENT_FULL  = VOL_W'(100);
  localparam logic [VOL_W-1:0]  VOL_RESET     = VOL_W'(10);
  localparam logic [CNT_W-1:0]  PERIOD_SAT    = '1;

  // ceil(2^30 / 100): exact divide by 100 for every product up to 65535 * 100
  localparam logic [RECIP_W-1:0] PULSE_RECIP = RECIP_W'(10737419);

  localparam logic [STAGE_W-1:0] DOUBLE_LAST = STAGE_W'(4);
  localparam logic [STAGE_W-1:0] TRIPLE_LAST = STAGE_W'(5);
  localparam logic [STAGE_W-1:0] SWEEP_LAST  = STAGE_W'(8);

  localparam logic [PAT_W-1:0] PAT_NONE   = PAT_W'(0);
  localparam logic [PAT_W-1:0] PAT_SINGLE = PAT_W'(1);
  localparam logic [PAT_W-1:0] PAT_DOUBLE = PAT_W'(2);
  localparam logic [PAT_W-1:0] PAT_TRIPLE = PAT_W'(3);
  localparam logic [PAT_W-1:0] PAT_SWEEP  = PAT_W'(4);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } bts_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_FREQ = 2'd0,
    CFG_VOLUME    = 2'd1
  } bts_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PER_START,
    S_PER_WAIT,
    S_PERIOD,
    S_PUL_MUL,
    S_PUL_SCALE,
    S_DONE
  } bts_state_t;

  typedef struct packed {
    logic accept;         // apply the request to the sequencer state
    logic div_start;      // load the divider with 1e6 / freq
    logic load_period;    // capture the period count
    logic load_prod;      // capture period * volume
    logic load_pulse;     // capture the product scaled down by 100
    logic load_out;       // fill the result register
  } bts_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic freq_low;       // frequency below 16 Hz, period saturates
    logic out_full;       // result register cannot take a new result
  } bts_status_t;

endpackage

// ===== design/bts_in_if.sv =====
// ---------------------------------------------------------------------------
// Beeper sequencer request and result channels
// Valid/ready channels: opcode and pattern number in, timer settings out.
// ---------------------------------------------------------------------------
interface bts_in_if;
  import bts_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PAT_W-1:0] pattern;

  modport source (output valid, output opcode, output pattern, input ready);
  modport sink (input valid, input opcode, input pattern, output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;

  logic             valid;
  logic             ready;
  logic             pwm_on;
  logic [CNT_W-1:0] period_count;
  logic [CNT_W-1:0] pulse_count;
  logic             busy_res;

  modport source (output valid, output pwm_on, output period_count, output pulse_count,
                  output busy_res, input ready);
  modport sink (input valid, input pwm_on, input period_count, input pulse_count,
                input busy_res, output ready);
endinterface

// ===== design/beeper_tone_pattern_sequencer.sv =====
// ---------------------------------------------------------------------------
// Beeper tone pattern sequencer
// Plays beeper patterns on 1 ms ticks and reports the PWM timer settings.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : requests, opcode 0 = 1 ms tick, 1 = start pattern (pattern no.)
//   out_ch : one result per request: pwm_on, period_count, pulse_count,
//            busy_res
//   cfg_*  : write-only registers, index 0 tone frequency (also loads the
//            current frequency), index 1 volume in percent; write while idle.
// Operation:
//   One request at a time. A request is taken in the idle state, then the
//   period is found by a serial 23-step division of 1e6 by the frequency and
//   the compare value by a reciprocal multiply of period * volume, with the
//   product and the scaled value registered in turn. Below 16 Hz the division
//   is skipped and the period saturates. The next request is taken the cycle
//   after the result is loaded, not before.
// Reset (synchronous, rst_n low): pattern 1 armed, stage 0, 1000 Hz,
//   volume 10 %, PWM off, result register empty.
// Stall: the result register holds its result until out_ch.ready; a request
//   can be taken while it waits, but the next result holds in the controller
//   until the register drains.
// ---------------------------------------------------------------------------
`include "beeper_tone_pattern_sequencer_defines.svh"

module beeper_tone_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  bts_in_if.sink                         in_ch,
  bts_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bts_pkg::*;

  bts_cmd_t    cmd;
  bts_status_t status;
  logic        ctrl_ready;

  // Controller: one request in flight, steps the datapath through divide
  // and scale.
  bts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctrl_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: pattern state, registers, divider and result register.
  bts_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_ch.opcode),
    .in_pattern       (in_ch.pattern),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_pwm_on       (out_ch.pwm_on),
    .out_period_count (out_ch.period_count),
    .out_pulse_count  (out_ch.pulse_count),
    .out_busy_res     (out_ch.busy_res)
  );

  assign in_ch.ready = ctrl_ready;

  // A taken request blocks further requests until its result is loaded.
  `BTS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // Starting the divider always leaves it busy for the following cycle.
  `BTS_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, status.div_busy)
  // Volume is clamped to full scale, so the compare never exceeds the period.
  `BTS_ASSERT_IMPL(a_pulse_le_period, clk, rst_n, out_ch.valid,
                   out_ch.pulse_count <= out_ch.period_count)
endmodule

// ===== design/bts_divider.sv =====
// ---------------------------------------------------------------------------
// Beeper sequencer serial divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bts_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bts_pkg::DIVD_W-1:0]   dividend,
  input  logic [bts_pkg::DIVS_W-1:0]   divisor,
  output logic                         busy,
  output logic [bts_pkg::DIVD_W-1:0]   quotient
);
  import bts_pkg::*;

  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W:0]      rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIVS_W:0]      rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r[DIVS_W-1:0], quo_r[DIVD_W-1]};
    ge       = (rem_sh >= {1'b0, dsr_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIVD_W-2:0], ge};
      rem_nxt  = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      busy_nxt = (cnt_r != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

// ===== design/bts_datapath.sv =====
// ---------------------------------------------------------------------------
// Beeper sequencer datapath
// Pattern state, registers, period/pulse arithmetic and result register.
// ---------------------------------------------------------------------------
module bts_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_opcode,
  input  logic [bts_pkg::PAT_W-1:0]      in_pattern,
  input  bts_pkg::bts_cmd_t              cmd,
  output bts_pkg::bts_status_t           status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_pwm_on,
  output logic [bts_pkg::CNT_W-1:0]      out_period_count,
  output logic [bts_pkg::CNT_W-1:0]      out_pulse_count,
  output logic                           out_busy_res
);
  import bts_pkg::*;

  logic [PAT_W-1:0]   active_r, active_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic [CD_W-1:0]    cd_r, cd_nxt;
  logic               first_r, first_nxt;
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic               pwm_r, pwm_nxt;
  logic [VOL_W-1:0]   vol_r, vol_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]   period_r;
  logic [DIVD_W-1:0]  prod_r;
  logic [CNT_W-1:0]   pulse_r;
  logic               out_pwm_r, out_busy_r;
  logic [CNT_W-1:0]   out_period_r, out_pulse_r;

  logic [STAGE_W-1:0] st;
  logic [CD_W-1:0]    cd_dec;
  logic               run_stage;
  logic               halt;
  logic [STAGE_W-1:0] last_stage;
  logic [VOL_W-1:0]   vol_eff;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic               div_busy;
  logic [DIVD_W-1:0]  div_quot;
  logic [SCALED_W-1:0] scaled;

  // Sequencer state update for one request or one register write.
  always_comb begin
    active_nxt = active_r;
    stage_nxt  = stage_r;
    cd_nxt     = cd_r;
    first_nxt  = first_r;
    freq_nxt   = freq_r;
    pwm_nxt    = pwm_r;
    vol_nxt    = vol_r;
    st         = first_r ? '0 : stage_r;
    cd_dec     = cd_r - CD_W'(1);
    run_stage  = 1'b0;
    halt       = 1'b0;
    last_stage = (active_r == PAT_DOUBLE) ? DOUBLE_LAST : TRIPLE_LAST;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TONE_FREQ: freq_nxt = cfg_data[FREQ_W-1:0];
        CFG_VOLUME:    vol_nxt  = cfg_data[VOL_W-1:0];
        default:       ;
      endcase
    end

    if (cmd.accept) begin
      if (in_opcode == OP_START) begin
        active_nxt = in_pattern;
      end else if (active_r != PAT_NONE) begin
        if (first_r) begin
          first_nxt = 1'b0;
          stage_nxt = '0;
          run_stage = 1'b1;
        end else begin
          cd_nxt    = cd_dec;
          run_stage = (cd_dec == '0);
        end
      end
    end

    if (run_stage) begin
      case (active_r)
        PAT_SINGLE: begin
          pwm_nxt = 1'b1;
          if (st != '0) begin
            halt = 1'b1;
          end else begin
            cd_nxt = SINGLE_BEEP_TICKS;
          end
        end
        PAT_DOUBLE, PAT_TRIPLE: begin
          if (active_r == PAT_DOUBLE) begin
            pwm_nxt = 1'b1;
          end
          if (st >= last_stage) begin
            halt = 1'b1;
          end else begin
            cd_nxt  = DOUBLE_STEP_TICKS;
            pwm_nxt = ~st[0];
          end
        end
        PAT_SWEEP: begin
          pwm_nxt = 1'b1;
          if (st >= SWEEP_LAST) begin
            freq_nxt = SWEEP_BASE_HZ;
            halt     = 1'b1;
          end else begin
            cd_nxt   = SWEEP_STEP_TICKS;
            freq_nxt = SWEEP_BASE_HZ - FREQ_W'(st[2:0]) * SWEEP_DELTA_HZ;
          end
        end
        default: halt = 1'b1;
      endcase
      if (halt) begin
        pwm_nxt    = 1'b0;
        stage_nxt  = '0;
        active_nxt = PAT_NONE;
        first_nxt  = 1'b1;
      end else begin
        stage_nxt = st + STAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= PAT_SINGLE;
      stage_r  <= '0;
      cd_r     <= CD_W'(1);
      first_r  <= 1'b1;
      freq_r   <= FREQ_RESET_HZ;
      pwm_r    <= 1'b0;
      vol_r    <= VOL_RESET;
    end else begin
      active_r <= active_nxt;
      stage_r  <= stage_nxt;
      cd_r     <= cd_nxt;
      first_r  <= first_nxt;
      freq_r   <= freq_nxt;
      pwm_r    <= pwm_nxt;
      vol_r    <= vol_nxt;
    end
  end

  // Divider computes 1e6 / freq; the compare value divides by 100 through
  // a reciprocal multiply.
  assign vol_eff      = (vol_r > PERCENT_FULL) ? PERCENT_FULL : vol_r;
  assign div_dividend = US_PER_SECOND;
  assign div_divisor  = freq_r;
  assign scaled       = SCALED_W'(prod_r) * SCALED_W'(PULSE_RECIP);

  bts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_period) begin
      period_r <= status.freq_low ? PERIOD_SAT : (div_quot[CNT_W-1:0] - CNT_W'(1));
    end
    if (cmd.load_prod) begin
      prod_r <= DIVD_W'(period_r) * DIVD_W'(vol_eff);
    end
    if (cmd.load_pulse) begin
      pulse_r <= scaled[PULSE_SHIFT +: CNT_W];
    end
    if (cmd.load_out) begin
      out_pwm_r    <= pwm_r;
      out_period_r <= period_r;
      out_pulse_r  <= pulse_r;
      out_busy_r   <= (active_r != PAT_NONE);
    end
  end

  // Result register: fill on load, drain when the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.div_busy = div_busy;
  assign status.freq_low = (freq_r < FREQ_MIN_HZ);
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_pwm_on       = out_pwm_r;
  assign out_period_count = out_period_r;
  assign out_pulse_count  = out_pulse_r;
  assign out_busy_res     = out_busy_r;
endmodule

// ===== design/bts_ctrl.sv =====
// ---------------------------------------------------------------------------
// Beeper sequencer controller
// Sequences state update, period division, pulse scaling and result load.
// ---------------------------------------------------------------------------
module bts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bts_pkg::bts_status_t status,
  output bts_pkg::bts_cmd_t    cmd
);
  import bts_pkg::*;

  bts_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_PER_START;
      S_PER_START: state_nxt = status.freq_low ? S_PERIOD : S_PER_WAIT;
      S_PER_WAIT:  if (!status.div_busy) state_nxt = S_PERIOD;
      S_PERIOD:    state_nxt = S_PUL_MUL;
      S_PUL_MUL:   state_nxt = S_PUL_SCALE;
      S_PUL_SCALE: state_nxt = S_DONE;
      S_DONE:      if (!status.out_full) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_PER_START: cmd.div_start = !status.freq_low;
      S_PER_WAIT:  ;
      S_PERIOD:    cmd.load_period = 1'b1;
      S_PUL_MUL:   cmd.load_prod = 1'b1;
      S_PUL_SCALE: cmd.load_pulse = 1'b1;
      S_DONE:      cmd.load_out = !status.out_full;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== bench/beeper_result_checker.sv =====
// ---------------------------------------------------------------------------
// Beeper sequencer result checker
// Watches the request, result and register ports, predicts the timer
// settings for every accepted request and compares them with the results.
// ---------------------------------------------------------------------------
module beeper_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  bts_in_if                              req_mon,
  bts_out_if                             res_mon,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic             pwm_on;
    logic [CNT_W-1:0] period_count;
    logic [CNT_W-1:0] pulse_count;
    logic             busy_res;
  } timer_setting_t;

  // Sequencer state as the block should hold it.
  logic [PAT_W-1:0]   pat_sel;
  logic [STAGE_W-1:0] stage;
  logic [CD_W-1:0]    countdown;
  logic               first_tick;
  logic [FREQ_W-1:0]  freq_now;
  logic [VOL_W-1:0]   vol_pct;
  logic               pwm;

  timer_setting_t timer_settings_q[$];

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one request to the sequencer and work out the timer settings.
  task automatic advance_sequencer(input logic op, input logic [PAT_W-1:0] pat,
                                   output timer_setting_t want);
    logic [STAGE_W-1:0] st;
    logic               run;
    logic               halt;
    logic [VOL_W-1:0]   duty;
    int                 period;

    if (op == OP_START) begin
      // stage, countdown and first-tick flag are kept
      pat_sel = pat;
    end else if (pat_sel != PAT_NONE) begin
      run = 1'b1;
      if (first_tick) begin
        first_tick = 1'b0;
        stage      = '0;
      end else begin
        countdown = countdown - 1'b1;
        if (countdown != '0) run = 1'b0;
      end
      if (run) begin
        st   = stage;
        halt = 1'b0;
        case (pat_sel)
          PAT_SINGLE: begin
            pwm = 1'b1;
            if (st != '0) halt = 1'b1;
            else countdown = SINGLE_BEEP_TICKS;
          end
          PAT_DOUBLE, PAT_TRIPLE: begin
            if (pat_sel == PAT_DOUBLE) pwm = 1'b1;
            if (st >= ((pat_sel == PAT_DOUBLE) ? DOUBLE_LAST : TRIPLE_LAST)) begin
              halt = 1'b1;
            end else begin
              countdown = DOUBLE_STEP_TICKS;
              pwm       = (st[0] == 1'b0);
            end
          end
          PAT_SWEEP: begin
            pwm = 1'b1;
            if (st >= SWEEP_LAST) begin
              freq_now = SWEEP_BASE_HZ;
              halt     = 1'b1;
            end else begin
              countdown = SWEEP_STEP_TICKS;
              freq_now  = SWEEP_BASE_HZ - SWEEP_DELTA_HZ * FREQ_W'(st);
            end
          end
          default: halt = 1'b1;
        endcase
        if (halt) begin
          // countdown is left where it stopped
          pwm        = 1'b0;
          stage      = '0;
          pat_sel    = PAT_NONE;
          first_tick = 1'b1;
        end else begin
          stage = st + 1'b1;
        end
      end
    end

    if (freq_now < FREQ_MIN_HZ) period = int'(PERIOD_SAT);
    else period = int'(US_PER_SECOND) / int'(freq_now) - 1;
    duty = (vol_pct > PERCENT_FULL) ? PERCENT_FULL : vol_pct;

    want.pwm_on       = pwm;
    want.period_count = CNT_W'(period);
    want.pulse_count  = CNT_W'(period * int'(duty) / int'(PERCENT_FULL));
    want.busy_res     = (pat_sel != PAT_NONE);
  endtask

  always @(posedge clk) begin
    timer_setting_t want;
    timer_setting_t got;
    if (!rst_n) begin
      pat_sel     = PAT_SINGLE;
      stage       = '0;
      countdown   = CD_W'(1);
      first_tick  = 1'b1;
      freq_now    = FREQ_RESET_HZ;
      vol_pct     = VOL_RESET;
      pwm         = 1'b0;
      mismatches  = 0;
      compared    = 0;
      timer_settings_q.delete();
    end else begin
      if (cfg_we) begin
        // the tone register only shows through the current frequency it loads
        case (cfg_index)
          CFG_TONE_FREQ: freq_now = cfg_data[FREQ_W-1:0];
          CFG_VOLUME:    vol_pct  = cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        advance_sequencer(req_mon.opcode, req_mon.pattern, want);
        timer_settings_q.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.pwm_on, res_mon.period_count, res_mon.pulse_count,
                res_mon.busy_res};
        if (timer_settings_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result pwm_on=%0d period=%0d pulse=%0d busy=%0d",
                                  got.pwm_on, got.period_count, got.pulse_count,
                                  got.busy_res));
        end else begin
          want = timer_settings_q.pop_front();
          if (got.pwm_on !== want.pwm_on)
            flag_mismatch($sformatf("result %0d pwm_on got %0d want %0d",
                                    compared, got.pwm_on, want.pwm_on));
          if (got.period_count !== want.period_count)
            flag_mismatch($sformatf("result %0d period_count got %0d want %0d",
                                    compared, got.period_count, want.period_count));
          if (got.pulse_count !== want.pulse_count)
            flag_mismatch($sformatf("result %0d pulse_count got %0d want %0d",
                                    compared, got.pulse_count, want.pulse_count));
          if (got.busy_res !== want.busy_res)
            flag_mismatch($sformatf("result %0d busy_res got %0d want %0d",
                                    compared, got.busy_res, want.busy_res));
        end
        compared++;
      end
    end
    outstanding = timer_settings_q.size();
  end

endmodule

// ===== bench/beeper_tone_pattern_sequencer_test.sv =====
// ---------------------------------------------------------------------------
// Beeper tone pattern sequencer testbench
// Drives tick and start requests through several register settings, with
// random gaps and result stalls; the result checker predicts and compares.
// ---------------------------------------------------------------------------
module beeper_tone_pattern_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  localparam int N_PHASES       = 10;
  localparam int N_CORNERS      = 7;
  localparam int N_LEAD         = 5;
  localparam int CALM_PHASE     = 3;
  localparam int PHASE_REQUESTS = 100;
  localparam int SETTLE_CYCLES  = 64;   // longer than one request's latency
  localparam int LEAD_MARGIN    = 64;   // covers any leftover countdown

  // Register indexes the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  // Corner settings for the first phases: saturating and extreme frequencies,
  // volume off, full, above full and at the 7-bit top.
  localparam logic [FREQ_W-1:0] FREQ_CORNERS [N_CORNERS] =
    '{16'd0, 16'd15, 16'd16, 16'd50000, 16'd65535, 16'd1, 16'd999};
  localparam logic [VOL_W-1:0] VOL_CORNERS [N_CORNERS] =
    '{7'd127, 7'd100, 7'd0, 7'd101, 7'd1, 7'd64, 7'd10};

  // Each of the first phases opens with one complete pattern; the last is an
  // unknown pattern number, which should stop on its first tick.
  localparam logic [PAT_W-1:0] LEAD_PATTERNS [N_LEAD] =
    '{PAT_SWEEP, PAT_TRIPLE, PAT_DOUBLE, PAT_SINGLE, 8'd200};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit calm;          // no gaps and no stalls on either side
  int fail_count;
  int pending;
  int n_compared;
  int n_sent;
  int n_starts;
  int n_ticks;
  int n_settings;

  bts_in_if  req_if ();
  bts_out_if res_if ();

  beeper_tone_pattern_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  beeper_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if),
    .res_mon     (res_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (fail_count),
    .outstanding (pending),
    .compared    (n_compared)
  );

  always #4 clk = ~clk;

  // Result side: stall on about 13 percent of cycles, never while calm.
  always @(negedge clk) begin
    res_if.ready <= calm || ($urandom_range(99) >= 13);
  end

  // Number of ticks that takes a pattern from its first tick to its stop.
  function automatic int ticks_to_finish(logic [PAT_W-1:0] pat);
    case (pat)
      PAT_SINGLE: return 1 + int'(SINGLE_BEEP_TICKS);
      PAT_DOUBLE: return 1 + int'(DOUBLE_LAST) * int'(DOUBLE_STEP_TICKS);
      PAT_TRIPLE: return 1 + int'(TRIPLE_LAST) * int'(DOUBLE_STEP_TICKS);
      PAT_SWEEP:  return 1 + int'(SWEEP_LAST) * int'(SWEEP_STEP_TICKS);
      default:    return 1;
    endcase
  endfunction

  // Present one request and hold it until the block takes it. Now and then
  // drop valid first, mostly briefly and rarely for longer than a request's
  // latency.
  task automatic send_request(bts_op_t op, logic [PAT_W-1:0] pat);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 13)
      gap = ($urandom_range(9) == 0) ? $urandom_range(5, 70) : $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.pattern <= pat;
    do @(posedge clk); while (!req_if.ready);
    n_sent++;
    if (op == OP_START) n_starts++;
    else n_ticks++;
  endtask

  // Start a pattern, then feed it ticks; the pattern field of a tick is noise.
  task automatic run_pattern(logic [PAT_W-1:0] pat, int ticks);
    send_request(OP_START, pat);
    repeat (ticks) send_request(OP_TICK, PAT_W'($urandom));
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain_and_settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
    logic [PAT_W-1:0]  pat;
    int                target;
    int                full;
    int                ticks;
    int                w;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_TONE_FREQ;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.opcode  = OP_TICK;
    req_if.pattern = PAT_NONE;
    res_if.ready   = 1'b0;
    calm           = 1'b0;
    n_sent         = 0;
    n_starts       = 0;
    n_ticks        = 0;
    n_settings     = 1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening on the reset settings (1000 Hz, volume 10).
    send_request(OP_TICK, PAT_NONE);          // single beep armed by reset
    send_request(OP_TICK, 8'hFF);
    send_request(OP_START, PAT_NONE);         // go idle, PWM stays on
    send_request(OP_TICK, PAT_NONE);          // idle tick changes nothing
    send_request(OP_START, PAT_DOUBLE);       // mid-pattern start keeps the stage
    send_request(OP_TICK, PAT_NONE);
    send_request(OP_START, PAT_W'(255));      // unknown pattern, not on a first tick
    send_request(OP_TICK, PAT_NONE);
    send_request(OP_START, PAT_SWEEP);
    send_request(OP_TICK, PAT_NONE);
    send_request(OP_START, PAT_TRIPLE);
    send_request(OP_TICK, PAT_NONE);
    send_request(OP_START, PAT_W'(128));
    send_request(OP_START, PAT_W'(85));
    send_request(OP_START, PAT_W'(170));
    send_request(OP_TICK, PAT_NONE);
    send_request(OP_START, PAT_SINGLE);
    repeat (6) send_request(OP_TICK, PAT_W'($urandom));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Registers change only with the block idle and nothing outstanding;
      // this also holds the sender until every result has come back.
      drain_and_settle();
      calm = (ph == CALM_PHASE);

      if (ph < N_CORNERS) begin
        freq = FREQ_CORNERS[ph];
        vol  = VOL_CORNERS[ph];
      end else begin
        w = $urandom_range(99);
        if (w < 15) freq = FREQ_W'($urandom_range(0, 15));
        else if (w < 60) freq = FREQ_W'($urandom_range(16, 5000));
        else freq = FREQ_W'($urandom_range(5001, 65535));
        vol = VOL_W'($urandom_range(0, 127));
      end

      // Random order; junk in the unused upper bits of the volume write.
      if ($urandom_range(1) == 1) begin
        write_register(CFG_TONE_FREQ, freq);
        write_register(CFG_VOLUME, {(CFG_DATA_W-VOL_W)'($urandom), vol});
      end else begin
        write_register(CFG_VOLUME, {(CFG_DATA_W-VOL_W)'($urandom), vol});
        write_register(CFG_TONE_FREQ, freq);
      end
      // Writes to indexes with no register behind them must be dropped.
      if (ph < 2 || $urandom_range(2) == 0)
        write_register((ph % 2 == 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                       CFG_DATA_W'($urandom));
      n_settings++;

      target = n_sent + PHASE_REQUESTS;
      if (ph < N_LEAD)
        run_pattern(LEAD_PATTERNS[ph], ticks_to_finish(LEAD_PATTERNS[ph]) + LEAD_MARGIN);

      while (n_sent < target) begin
        if ($urandom_range(99) < 80) begin
          // Well-formed run: start and enough ticks to finish, or cut short
          // so that the next start lands mid-pattern.
          w = $urandom_range(99);
          if (w < 35) pat = PAT_SINGLE;
          else if (w < 55) pat = PAT_DOUBLE;
          else if (w < 72) pat = PAT_TRIPLE;
          else if (w < 86) pat = PAT_SWEEP;
          else pat = PAT_W'($urandom_range(5, 255));
          full  = ticks_to_finish(pat);
          ticks = ($urandom_range(1) == 1) ? full + $urandom_range(0, 4)
                                           : $urandom_range(1, full);
          // Keep the phase close to its request budget.
          if (ticks > target - n_sent - 1) ticks = target - n_sent - 1;
          run_pattern(pat, ticks);
        end else begin
          // Noise: any pattern number, zero included, mixed with stray ticks.
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 1) send_request(OP_START, PAT_W'($urandom));
            else send_request(OP_TICK, PAT_W'($urandom));
          end
        end
      end
    end

    calm = 1'b0;
    drain_and_settle();

    $display("covered %0d requests (%0d starts, %0d ticks) under %0d register settings",
             n_sent, n_starts, n_ticks, n_settings);
    $display("compared %0d results, %0d mismatches", n_compared, fail_count);
    if (fail_count == 0) begin
      $display("PASS beeper_tone_pattern_sequencer");
    end else begin
      $display("FAIL beeper_tone_pattern_sequencer");
    end
    $finish;
  end

  // Hard stop, several times the slowest correct run.
  initial begin
    #10ms;
    $display("timed out with %0d results outstanding", pending);
    $display("FAIL beeper_tone_pattern_sequencer");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bts_pkg.sv
design/bts_in_if.sv
design/bts_divider.sv
design/bts_datapath.sv
design/bts_ctrl.sv
design/beeper_tone_pattern_sequencer.sv
bench/beeper_result_checker.sv
bench/beeper_tone_pattern_sequencer_test.sv
